@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers shared by the parser modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, skipped while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property at every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/kvcp_pkg.sv @@
// ---------------------------------------------------------------------------
// kvcp_pkg
// Types, character codes and colour name tables of the colour config parser.
// ---------------------------------------------------------------------------
`default_nettype none

package kvcp_pkg;

  localparam int NAME_COUNT = 9;
  localparam int NAME_MAX   = 6;
  localparam int PREFIX_LEN = 4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  localparam logic [2:0] KEY_POS_MAX = 3'd7;

  typedef enum logic [1:0] {
    PH_KEY   = 2'd0,
    PH_VALUE = 2'd1,
    PH_SKIP  = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] colour_code;
    logic [3:0] colour_index;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam logic [2:0] NAME_LEN [NAME_COUNT] = '{
    3'd3, 3'd5, 3'd4, 3'd6, 3'd6, 3'd6, 3'd5, 3'd5, 3'd5
  };

  // "CFG:"
  function automatic logic [7:0] prefix_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = 8'h43;
      2'd1:    c = 8'h46;
      2'd2:    c = 8'h47;
      default: c = 8'h3A;
    endcase
    return c;
  endfunction

  // Red Green Blue Yellow Purple Orange Black White Brown
  function automatic logic [7:0] name_char(input logic [3:0] idx, input logic [2:0] pos);
    logic [47:0] txt;
    logic [7:0]  c;
    case (idx)
      4'd0:    txt = {8'h00, 8'h00, 8'h00, "d", "e", "R"};
      4'd1:    txt = {8'h00, "n", "e", "e", "r", "G"};
      4'd2:    txt = {8'h00, 8'h00, "e", "u", "l", "B"};
      4'd3:    txt = {"w", "o", "l", "l", "e", "Y"};
      4'd4:    txt = {"e", "l", "p", "r", "u", "P"};
      4'd5:    txt = {"e", "g", "n", "a", "r", "O"};
      4'd6:    txt = {8'h00, "k", "c", "a", "l", "B"};
      4'd7:    txt = {8'h00, "e", "t", "i", "h", "W"};
      4'd8:    txt = {8'h00, "n", "w", "o", "r", "B"};
      default: txt = '0;
    endcase
    case (pos)
      3'd0:    c = txt[7:0];
      3'd1:    c = txt[15:8];
      3'd2:    c = txt[23:16];
      3'd3:    c = txt[31:24];
      3'd4:    c = txt[39:32];
      3'd5:    c = txt[47:40];
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ design/key_value_colour_config_parser.sv @@
// ---------------------------------------------------------------------------
// key_value_colour_config_parser
// Finds Colour=Value tokens in a byte stream and emits colour setting codes.
// ---------------------------------------------------------------------------
//  port group  dir  tdata bits                                   tlast
//  s_*         in   [7:0] msg_byte                               last_byte
//  m_*         out  [3:0] colour_index, [11:4] colour_code       -
//
//  One byte is taken per cycle while s_tready is high; the parser state updates in the same cycle.
//  A result passes from its value byte through the queue and the output register to m_tvalid.
//  s_tready drops only while the QUEUE_DEPTH-entry result queue is full.
//  Synchronous reset rst clears parser state, queue and output valid.
// ---------------------------------------------------------------------------
`default_nettype none

module key_value_colour_config_parser #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // [7:0] msg_byte
  input  wire         s_tlast,
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [15:0] m_tdata    // [3:0] colour_index, [11:4] colour_code, [15:12] zero
);

  kvcp_pkg::q_stat_t  q_stat;
  kvcp_pkg::result_t  push_item;
  kvcp_pkg::result_t  pop_item;
  kvcp_pkg::result_t  out_item;
  logic               push;
  logic               pop;

  kvcp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .in_last   (s_tlast),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  kvcp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  kvcp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .pop_item  (pop_item),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (out_item)
  );

  assign m_tdata = {4'b0000, out_item.colour_code, out_item.colour_index};

endmodule

`default_nettype wire

@@ design/kvcp_front.sv @@
// ---------------------------------------------------------------------------
// kvcp_front
// Byte parser: prefix skip, key matching and value capture, one byte a cycle while the queue is not full.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module kvcp_front (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire  [7:0]          in_byte,
  input  wire                 in_last,
  input  kvcp_pkg::q_stat_t   q_stat,
  output logic                push,
  output kvcp_pkg::result_t   push_item
);

  logic                   accept;
  logic [2:0]             prefix_count, prefix_count_next;
  logic                   prefix_alive, prefix_alive_next;
  logic [2:0]             key_position, key_position_next;
  logic [8:0]             key_candidates, key_candidates_next;
  kvcp_pkg::phase_t       phase, phase_next;
  logic [3:0]             matched_colour, matched_colour_next;
  logic                   prefix_done;
  logic                   hit;
  logic [8:0]             keep;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    prefix_count_next   = prefix_count;
    prefix_alive_next   = prefix_alive;
    key_position_next   = key_position;
    key_candidates_next = key_candidates;
    phase_next          = phase;
    matched_colour_next = matched_colour;
    prefix_done         = 1'b0;
    hit                 = 1'b0;
    keep                = '0;
    push                = 1'b0;
    push_item.colour_index = matched_colour;
    push_item.colour_code  = in_byte;

    if (phase != kvcp_pkg::PH_DONE) begin
      if (prefix_alive) begin
        if (prefix_count < 3'(kvcp_pkg::PREFIX_LEN) &&
            in_byte == kvcp_pkg::prefix_char(prefix_count[1:0])) begin
          prefix_count_next = prefix_count + 3'd1;
          if (prefix_count_next == 3'(kvcp_pkg::PREFIX_LEN)) begin
            prefix_done       = 1'b1;
            prefix_alive_next = 1'b0;
          end
        end else begin
          prefix_alive_next = 1'b0;
        end
      end

      if (in_byte == kvcp_pkg::CH_NUL) begin
        phase_next = kvcp_pkg::PH_DONE;
      end else if (in_byte == kvcp_pkg::CH_COMMA) begin
        key_position_next   = '0;
        key_candidates_next = '1;
        phase_next          = kvcp_pkg::PH_KEY;
      end else if (phase == kvcp_pkg::PH_KEY) begin
        if (in_byte == kvcp_pkg::CH_EQ) begin
          for (int i = 0; i < kvcp_pkg::NAME_COUNT; i++) begin
            if (key_candidates[i] && kvcp_pkg::NAME_LEN[i] == key_position) begin
              matched_colour_next = 4'(i);
              hit                 = 1'b1;
            end
          end
          phase_next = hit ? kvcp_pkg::PH_VALUE : kvcp_pkg::PH_SKIP;
        end else begin
          for (int i = 0; i < kvcp_pkg::NAME_COUNT; i++) begin
            keep[i] = key_candidates[i] && key_position < kvcp_pkg::NAME_LEN[i] &&
                      kvcp_pkg::name_char(4'(i), key_position) == in_byte;
          end
          key_candidates_next = keep;
          if (key_position < kvcp_pkg::KEY_POS_MAX) begin
            key_position_next = key_position + 3'd1;
          end
        end
      end else if (phase == kvcp_pkg::PH_VALUE) begin
        push       = accept;
        phase_next = kvcp_pkg::PH_SKIP;
      end

      // drop the prefix bytes from the key
      if (prefix_done && phase_next != kvcp_pkg::PH_DONE) begin
        key_position_next   = '0;
        key_candidates_next = '1;
        phase_next          = kvcp_pkg::PH_KEY;
      end
    end

    if (in_last) begin
      prefix_count_next   = '0;
      prefix_alive_next   = 1'b1;
      matched_colour_next = '0;
      key_position_next   = '0;
      key_candidates_next = '1;
      phase_next          = kvcp_pkg::PH_KEY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_count   <= '0;
      prefix_alive   <= 1'b1;
      key_position   <= '0;
      key_candidates <= '1;
      phase          <= kvcp_pkg::PH_KEY;
      matched_colour <= '0;
    end else if (accept) begin
      prefix_count   <= prefix_count_next;
      prefix_alive   <= prefix_alive_next;
      key_position   <= key_position_next;
      key_candidates <= key_candidates_next;
      phase          <= phase_next;
      matched_colour <= matched_colour_next;
    end
  end

  `ASSERT_CLK(a_push_from_value, clk, rst, push |-> (accept && phase == kvcp_pkg::PH_VALUE && matched_colour <= 4'd8), "push outside value phase")
  `ASSERT_CLK(a_prefix_bound, clk, rst, prefix_count <= 3'(kvcp_pkg::PREFIX_LEN), "prefix count overrun")

endmodule

`default_nettype wire

@@ design/kvcp_queue.sv @@
// ---------------------------------------------------------------------------
// kvcp_queue
// Small result queue between the parser and the output stage.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module kvcp_queue #(
  parameter int DEPTH = 4
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  input  kvcp_pkg::result_t   push_item,
  input  wire                 pop,
  output kvcp_pkg::result_t   pop_item,
  output kvcp_pkg::q_stat_t   q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  kvcp_pkg::result_t  mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign q_stat.full  = (count == CNT_W'(DEPTH));
  assign q_stat.empty = (count == '0);
  assign pop_item     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_CLK(a_no_overflow, clk, rst, !(push && q_stat.full), "push into full queue")
  `ASSERT_CLK(a_no_underflow, clk, rst, !(pop && q_stat.empty), "pop from empty queue")
  `ASSERT_CLK(a_count_up, clk, rst, (push && !pop) |=> (count == $past(count) + 1'b1), "count did not advance")

endmodule

`default_nettype wire

@@ design/kvcp_back.sv @@
// ---------------------------------------------------------------------------
// kvcp_back
// Output stage: registers one result word and hands it downstream.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module kvcp_back (
  input  wire                 clk,
  input  wire                 rst,
  input  kvcp_pkg::q_stat_t   q_stat,
  input  kvcp_pkg::result_t   pop_item,
  output logic                pop,
  output logic                out_valid,
  input  wire                 out_ready,
  output kvcp_pkg::result_t   out_item
);

  // advance when the output register is free or being drained
  assign pop = !q_stat.empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= !q_stat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item <= pop_item;
    end
  end

  `ASSERT_CLK(a_index_range, clk, rst, out_valid |-> (out_item.colour_index <= 4'd8), "colour index out of range")
  `ASSERT_CLK(a_load_from_pop, clk, rst, (!out_valid && !q_stat.empty) |=> out_valid, "output stage missed a word")

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Testbench of key_value_colour_config_parser. Directed messages, then random
// messages built mostly from well-formed Colour=Value tokens with broken ones
// mixed in. A scoreboard tracks the parser state, predicts every colour
// setting from the bytes it accepts and checks each word on the result side.
// ---------------------------------------------------------------------------

module tb;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BYTES = 1800;

  class colour_scoreboard;
    string names [kvcp_pkg::NAME_COUNT] = '{"Red", "Green", "Blue", "Yellow", "Purple",
                                            "Orange", "Black", "White", "Brown"};
    string prefix = "CFG:";

    logic [2:0]        prefix_count;
    bit                prefix_alive;
    logic [2:0]        key_pos;
    logic [8:0]        candidates;
    kvcp_pkg::phase_t  phase;
    logic [3:0]        matched;
    kvcp_pkg::result_t colour_settings [$];
    int                errors;

    function new();
      errors = 0;
      reset_parser();
    endfunction

    function void clear_key();
      key_pos    = '0;
      candidates = '1;
      phase      = kvcp_pkg::PH_KEY;
    endfunction

    function void reset_parser();
      prefix_count = '0;
      prefix_alive = 1'b1;
      matched      = '0;
      clear_key();
    endfunction

    function int pending();
      return colour_settings.size();
    endfunction

    // Advance the parser by one accepted byte and queue any setting it emits.
    function void note_byte(logic [7:0] b, logic last);
      bit                prefix_done;
      bit                hit;
      logic [8:0]        keep;
      kvcp_pkg::result_t setting;
      prefix_done = 1'b0;
      if (phase != kvcp_pkg::PH_DONE) begin
        if (prefix_alive) begin
          if (prefix_count < kvcp_pkg::PREFIX_LEN && b == 8'(prefix[prefix_count])) begin
            prefix_count = prefix_count + 3'd1;
            if (prefix_count == kvcp_pkg::PREFIX_LEN) begin
              prefix_done  = 1'b1;
              prefix_alive = 1'b0;
            end
          end else begin
            prefix_alive = 1'b0;
          end
        end
        if (b == kvcp_pkg::CH_NUL) begin
          phase = kvcp_pkg::PH_DONE;
        end else if (b == kvcp_pkg::CH_COMMA) begin
          clear_key();
        end else if (phase == kvcp_pkg::PH_KEY) begin
          if (b == kvcp_pkg::CH_EQ) begin
            hit = 1'b0;
            for (int i = 0; i < kvcp_pkg::NAME_COUNT; i++) begin
              if (candidates[i] && names[i].len() == key_pos) begin
                matched = 4'(i);
                hit     = 1'b1;
              end
            end
            phase = hit ? kvcp_pkg::PH_VALUE : kvcp_pkg::PH_SKIP;
          end else begin
            keep = '0;
            for (int i = 0; i < kvcp_pkg::NAME_COUNT; i++) begin
              if (candidates[i] && key_pos < names[i].len() &&
                  8'(names[i][key_pos]) == b)
                keep[i] = 1'b1;
            end
            candidates = keep;
            if (key_pos != kvcp_pkg::KEY_POS_MAX)
              key_pos = key_pos + 3'd1;
          end
        end else if (phase == kvcp_pkg::PH_VALUE) begin
          setting.colour_index = matched;
          setting.colour_code  = b;
          colour_settings.push_back(setting);
          phase = kvcp_pkg::PH_SKIP;
        end
        if (prefix_done && phase != kvcp_pkg::PH_DONE)
          clear_key();
      end
      if (last)
        reset_parser();
    endfunction

    function void check_result(logic [15:0] word);
      kvcp_pkg::result_t want;
      if (colour_settings.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected word index=%0d code=%02h", $realtime,
                   word[3:0], word[11:4]);
        return;
      end
      want = colour_settings.pop_front();
      if (word[3:0] != want.colour_index || word[11:4] != want.colour_code) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch index exp=%0d act=%0d code exp=%02h act=%02h",
                   $realtime, want.colour_index, word[3:0], want.colour_code,
                   word[11:4]);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int cycles = 0;

  logic [7:0] msg_bytes [$];
  colour_scoreboard sb = new();

  key_value_colour_config_parser DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Note inputs before checking outputs within the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        sb.note_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready)
        sb.check_result(m_tdata);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_message();
    foreach (msg_bytes[i])
      send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    msg_bytes.delete();
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++)
      msg_bytes.push_back(8'(s[i]));
  endtask

  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Build one random message; live_count is the number of bytes up to its end.
  task automatic build_message(output int live_count);
    int    sel;
    int    ntok;
    int    k;
    string nm;
    sel = $urandom_range(9);
    if (sel < 5) begin
      push_text("CFG:");
    end else if (sel < 7) begin
      k = $urandom_range(1, 3);
      for (int j = 0; j < k; j++)
        msg_bytes.push_back(8'(sb.prefix[j]));
      if ($urandom_range(1))
        msg_bytes.push_back(kvcp_pkg::CH_COMMA);
    end
    ntok = $urandom_range(1, 5);
    for (int t = 0; t < ntok; t++) begin
      if (t > 0)
        msg_bytes.push_back(kvcp_pkg::CH_COMMA);
      nm  = sb.names[$urandom_range(kvcp_pkg::NAME_COUNT - 1)];
      sel = $urandom_range(99);
      if (sel < 55) begin
        push_text(nm);
        msg_bytes.push_back(kvcp_pkg::CH_EQ);
        msg_bytes.push_back(8'($urandom_range(1, 255)));
        k = $urandom_range(3);
        repeat (k) msg_bytes.push_back(8'($urandom_range(65, 122)));
      end else if (sel < 62) begin
        // one key letter replaced
        nm[$urandom_range(nm.len() - 1)] = byte'($urandom_range(65, 122));
        push_text(nm);
        msg_bytes.push_back(kvcp_pkg::CH_EQ);
        msg_bytes.push_back(8'($urandom_range(1, 255)));
      end else if (sel < 69) begin
        // key runs past the name
        push_text(nm);
        k = $urandom_range(1, 3);
        repeat (k) msg_bytes.push_back(8'($urandom_range(65, 122)));
        msg_bytes.push_back(kvcp_pkg::CH_EQ);
        msg_bytes.push_back(8'($urandom_range(1, 255)));
      end else if (sel < 75) begin
        push_text(nm);
      end else if (sel < 81) begin
        push_text(nm);
        msg_bytes.push_back(kvcp_pkg::CH_EQ);
      end else if (sel < 86) begin
        push_text(nm);
        msg_bytes.push_back(kvcp_pkg::CH_EQ);
        msg_bytes.push_back(kvcp_pkg::CH_EQ);
      end else if (sel < 90) begin
        // truncated key
        k = $urandom_range(1, nm.len() - 1);
        for (int j = 0; j < k; j++)
          msg_bytes.push_back(8'(nm[j]));
        msg_bytes.push_back(kvcp_pkg::CH_EQ);
        msg_bytes.push_back(8'($urandom_range(1, 255)));
      end else if (sel >= 94) begin
        k = $urandom_range(1, 6);
        repeat (k) msg_bytes.push_back(8'($urandom_range(255)));
      end
    end
    if ($urandom_range(4) == 0)
      msg_bytes.push_back(kvcp_pkg::CH_COMMA);
    if ($urandom_range(99) < 55)
      msg_bytes.push_back(kvcp_pkg::CH_NUL);
    if (msg_bytes.size() == 0)
      msg_bytes.push_back(8'($urandom_range(1, 255)));
    live_count = msg_bytes.size();
    // bytes after the end of message are ignored until the last mark
    if (msg_bytes[msg_bytes.size() - 1] == kvcp_pkg::CH_NUL) begin
      k = $urandom_range(3);
      repeat (k) msg_bytes.push_back(8'($urandom_range(255)));
    end
  endtask

  initial begin
    int src_pct  [3] = '{22, 50, 0};
    int sink_pct [3] = '{50, 22, 0};
    int sent;
    int live;
    bit drained;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int p = 0; p < 3; p++) begin
      src_idle_pct  = src_pct[p];
      sink_idle_pct = sink_pct[p];
      if (p == 0) begin
        // full prefix, extreme code, empty token, empty value, junk after end
        push_text("CFG:Red=");
        msg_bytes.push_back(8'hFF);
        push_text(",,Blue=,");
        msg_bytes.push_back(kvcp_pkg::CH_NUL);
        push_text("Z");
        send_message();
        // broken prefix still parsed as a key; result on the last byte
        push_text("CFG,Brown=");
        msg_bytes.push_back(8'h01);
        send_message();
      end
      sent    = 0;
      drained = 1'b0;
      while (sent < RANDOM_BYTES / 3) begin
        build_message(live);
        send_message();
        sent += live;
        if (!drained && sent >= RANDOM_BYTES / 6) begin
          hold_until_drained();
          drained = 1'b1;
        end
      end
      hold_until_drained();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
